FILE: design/hmn_pkg.sv
package hmn_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_LOAD
  } state_t;

  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_IMAGE_ROWS  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_GAIN = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam int ROOT_STEPS = 31;
  localparam int DIV_STEPS  = 17;

  typedef struct packed {
    logic       capture;
    logic       read;
    logic       eval;
    logic       mul;
    logic       square;
    logic       sum;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] sel;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic emit;
    logic out_free;
  } status_t;

endpackage

FILE: design/hmn_ctrl.sv
module hmn_ctrl
  import hmn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [4:0] cnt;
  logic [1:0] sel;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept && !status.ignore) state_next = ST_READ;
      ST_READ:     state_next = ST_EVAL;
      ST_EVAL:     state_next = status.emit ? ST_MUL : ST_IDLE;
      ST_MUL:      state_next = ST_SQUARE;
      ST_SQUARE:   state_next = ST_SUM;
      ST_SUM:      state_next = ST_ROOT;
      ST_ROOT:     if (cnt == 5'd0) state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (cnt == 5'd0) state_next = ST_DIV_END;
      ST_DIV_END:  state_next = (sel == COMP_Z) ? ST_LOAD : ST_DIV_INIT;
      ST_LOAD:     if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = sel;
    in_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = accept;
      end
      ST_READ:     cmd.read = 1'b1;
      ST_EVAL:     cmd.eval = 1'b1;
      ST_MUL:      cmd.mul = 1'b1;
      ST_SQUARE:   cmd.square = 1'b1;
      ST_SUM:      cmd.sum = 1'b1;
      ST_ROOT:     cmd.root_step = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_DIV_END:  cmd.div_store = 1'b1;
      ST_LOAD:     cmd.load = status.out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= COMP_X;
    end else begin
      state <= state_next;
      case (state)
        ST_SUM:      cnt <= 5'(ROOT_STEPS - 1);
        ST_ROOT:     if (cnt == 5'd0) sel <= COMP_X; else cnt <= cnt - 5'd1;
        ST_DIV_INIT: cnt <= 5'(DIV_STEPS - 1);
        ST_DIV:      if (cnt != 5'd0) cnt <= cnt - 5'd1;
        ST_DIV_END:  sel <= sel + 2'd1;
        default:     cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: design/hmn_datapath.sv
module hmn_datapath
  import hmn_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        func,
  input  logic [15:0] height_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] normal_x,
  output logic [15:0] normal_y,
  output logic [15:0] normal_z,
  output logic [9:0]  pixel_column,
  output logic [9:0]  pixel_row,
  output logic        frame_end
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RB = $clog2(MAX_ROWS + 1);

  logic [10:0] image_width, image_rows;
  logic [15:0] height_gain;

  logic [15:0] row_above_store [MAX_WIDTH];
  logic [15:0] row_middle_store [MAX_WIDTH];
  logic [15:0] mid_q0, mid_q1, above_q;

  logic [15:0]   sample_window;
  logic [CB-1:0] col;
  logic [RB-1:0] row;
  logic          f_r;
  logic [15:0]   s_r;

  logic [31:0]   w32, w_sat32, r32, r_sat32;
  logic [WW-1:0] w_use, c1;
  logic [RB-1:0] rows_use;
  logic          draining;

  logic signed [15:0] center, left, right, up, down;
  logic signed [16:0] dx_n, dz_n, dx, dz;
  logic               emit_n, fend_n;
  logic [CB-1:0]      pcol;
  logic [RB-1:0]      prow;
  logic               pfend;
  logic [31:0]        col32, row32;

  logic signed [33:0] px, pz;
  logic [33:0]        pxa, pza;
  logic [29:0]        mx, mz;
  logic               negx, negz;
  logic [59:0]        sqx, sqz;
  logic [61:0]        rs, rres, rbit, rtry;
  logic [47:0]        drem, ddiv;
  logic [16:0]        quo;
  logic [29:0]        m_sel;
  logic               neg_sel;
  logic [17:0]        pos_sum;
  logic [15:0]        comp_val;
  logic [15:0]        nx, ny, nz;

  assign w32      = 32'(image_width);
  assign w_sat32  = (w32 == 32'd0) ? 32'd1 : (w32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w32;
  assign w_use    = w_sat32[WW-1:0];
  assign r32      = 32'(image_rows);
  assign r_sat32  = (r32 == 32'd0) ? 32'd1 : (r32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : r32;
  assign rows_use = r_sat32[RB-1:0];
  assign draining = row >= rows_use;
  assign c1       = WW'(col) + WW'(1);

  assign status.ignore   = func ? !draining : draining;
  assign status.emit     = emit_n;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    center = $signed(mid_q0);
    left   = (col != '0) ? $signed(sample_window) : center;
    right  = (c1 < w_use) ? $signed(mid_q1) : center;
    up     = (row > RB'(1)) ? $signed(above_q) : center;
    down   = f_r ? center : $signed(s_r);
    dx_n   = {left[15], left} - {right[15], right};
    dz_n   = {up[15], up} - {down[15], down};
    emit_n = f_r || (row != '0);
    fend_n = f_r && !(c1 < w_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_rows  <= 11'd1024;
      height_gain <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: image_width <= cfg_data[10:0];
        CFG_IMAGE_ROWS:  image_rows  <= cfg_data[10:0];
        CFG_HEIGHT_GAIN: height_gain <= cfg_data;
        default:         image_width <= image_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      mid_q0  <= row_middle_store[col];
      mid_q1  <= row_middle_store[c1[CB-1:0]];
      above_q <= row_above_store[col];
    end
    if (cmd.eval && !f_r) begin
      row_above_store[col]  <= mid_q0;
      row_middle_store[col] <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window <= '0;
      col           <= '0;
      row           <= '0;
    end else if (cmd.eval) begin
      sample_window <= mid_q0;
      if (c1 < w_use) begin
        col <= c1[CB-1:0];
      end else begin
        col <= '0;
        row <= f_r ? '0 : RB'(row + RB'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      f_r <= func;
      s_r <= height_sample;
    end
    if (cmd.eval) begin
      dx    <= dx_n;
      dz    <= dz_n;
      pcol  <= col;
      prow  <= RB'(row - RB'(1));
      pfend <= fend_n;
    end
  end

  assign px  = dx * $signed({1'b0, height_gain});
  assign pz  = dz * $signed({1'b0, height_gain});
  assign pxa = px[33] ? 34'(-px) : px;
  assign pza = pz[33] ? 34'(-pz) : pz;

  assign rtry = rres + rbit;

  always_comb begin
    case (cmd.sel)
      COMP_X:  begin m_sel = mx; neg_sel = negx; end
      COMP_Y:  begin m_sel = 30'(1 << 20); neg_sel = 1'b0; end
      COMP_Z:  begin m_sel = mz; neg_sel = negz; end
      default: begin m_sel = mx; neg_sel = negx; end
    endcase
    pos_sum = 18'd32768 + 18'(quo);
    if (neg_sel) begin
      comp_val = (quo >= 17'd32768) ? 16'd0 : 16'(17'd32768 - quo);
    end else begin
      comp_val = (pos_sum > 18'd65535) ? 16'hFFFF : pos_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mx   <= pxa[32:3];
      mz   <= pza[32:3];
      negx <= px[33];
      negz <= pz[33];
    end
    if (cmd.square) begin
      sqx <= mx * mx;
      sqz <= mz * mz;
    end
    if (cmd.sum) begin
      rs   <= 62'(sqx) + 62'(sqz) + (62'(1) << 40);
      rres <= '0;
      rbit <= 62'(1) << 60;
    end
    if (cmd.root_step) begin
      if (rs >= rtry) begin
        rs   <= rs - rtry;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.div_init) begin
      drem <= 48'({m_sel, 15'b0}) + 48'(rres[31:1]);
      ddiv <= {rres[31:0], 16'b0};
      quo  <= '0;
    end
    if (cmd.div_step) begin
      if (drem >= ddiv) begin
        drem <= drem - ddiv;
        quo  <= {quo[15:0], 1'b1};
      end else begin
        quo  <= {quo[15:0], 1'b0};
      end
      ddiv <= ddiv >> 1;
    end
    if (cmd.div_store) begin
      case (cmd.sel)
        COMP_X:  nx <= comp_val;
        COMP_Y:  ny <= comp_val;
        COMP_Z:  nz <= comp_val;
        default: nx <= nx;
      endcase
    end
  end

  assign col32 = 32'(pcol);
  assign row32 = 32'(prow);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      normal_x     <= nx;
      normal_y     <= ny;
      normal_z     <= nz;
      pixel_column <= col32[9:0];
      pixel_row    <= row32[9:0];
      frame_end    <= pfend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready)) else $error("load over pending result");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid) else $error("result lost after load");
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row) <= 32'(MAX_ROWS)) else $error("row counter out of range");
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (rres[61:20] != '0)) else $error("root below unit vector");
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_store |-> (quo <= 17'd32768)) else $error("quotient out of range");
`endif

endmodule

FILE: design/height_map_to_normal_map.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   func, height_sample
// out      out_valid / out_ready normal_x, normal_y, normal_z, pixel_column,
//                                pixel_row, frame_end
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An ignored item keeps the controller idle; a first-row sample gives no result.
// An item with a result passes line store read, products, squares,
// a 31-step bit-serial square root and three 17-step divisions in one divider.
// The output register holds a result while the next item is taken in.
// Synchronous reset clears counters, window, config and out_valid; line stores stay.
module height_map_to_normal_map
  import hmn_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] height_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] normal_x,
  output logic [15:0] normal_y,
  output logic [15:0] normal_z,
  output logic [9:0]  pixel_column,
  output logic [9:0]  pixel_row,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hmn_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .height_sample (height_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .frame_end     (frame_end)
  );

endmodule

FILE: tb/sv/height_map_to_normal_map_chk.sv
`timescale 1ns / 100ps

module height_map_to_normal_map_chk
  import hmn_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [15:0] height_sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] normal_x,
  input  logic [15:0] normal_y,
  input  logic [15:0] normal_z,
  input  logic [9:0]  pixel_column,
  input  logic [9:0]  pixel_row,
  input  logic        frame_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [9:0]  col;
    logic [9:0]  row;
    logic        fend;
  } normal_t;

  normal_t     expected_normals[$];
  logic [15:0] above_line[MAX_WIDTH];
  logic [15:0] middle_line[MAX_WIDTH];
  logic [15:0] prev_center;
  int unsigned col_cnt, row_cnt;
  int unsigned width_reg, rows_reg, gain_reg;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] map_component(longint unsigned m, bit neg,
                                                 longint unsigned r);
    longint unsigned q, o;
    q = (m * 32768 + r / 2) / r;
    if (neg) o = (q >= 32768) ? 0 : 32768 - q;
    else o = 32768 + q;
    return (o > 65535) ? 16'hFFFF : o[15:0];
  endfunction

  function automatic normal_t shade(int hl, int hr, int hu, int hd,
                                    int unsigned col, int unsigned row, bit fend);
    normal_t n;
    longint px, pz;
    longint unsigned mx, mz, my, r;
    px = longint'(hl - hr) * longint'(gain_reg);
    pz = longint'(hu - hd) * longint'(gain_reg);
    mx = longint'(px < 0 ? -px : px) >> 3;
    mz = longint'(pz < 0 ? -pz : pz) >> 3;
    my = 64'd1 << 20;
    r = int_sqrt(mx * mx + my * my + mz * mz);
    n.nx = map_component(mx, px < 0, r);
    n.ny = map_component(my, 1'b0, r);
    n.nz = map_component(mz, pz < 0, r);
    n.col = col[9:0];
    n.row = row[9:0];
    n.fend = fend;
    return n;
  endfunction

  task automatic predict_pixel(logic f, logic [15:0] s);
    int unsigned w, rows, c;
    bit draining;
    int center, left, right, up, down;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    rows = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg);
    draining = row_cnt >= rows;
    c = (col_cnt >= MAX_WIDTH) ? 0 : col_cnt;
    if ((f == FUNC_SAMPLE && draining) || (f == FUNC_FLUSH && !draining)) return;
    center = $signed(middle_line[c]);
    left = (c > 0) ? $signed(prev_center) : center;
    right = (c + 1 < w) ? $signed(middle_line[c + 1]) : center;
    up = (row_cnt >= 2) ? $signed(above_line[c]) : center;
    prev_center = center[15:0];
    if (f == FUNC_SAMPLE) begin
      down = $signed(s);
      if (row_cnt >= 1) expected_normals.push_back(shade(left, right, up, down, c,
                                                         row_cnt - 1, 1'b0));
      above_line[c] = middle_line[c];
      middle_line[c] = s;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt++;
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      down = center;
      expected_normals.push_back(shade(left, right, up, down, c, row_cnt - 1,
                                       c + 1 >= w));
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = 0;
      end else begin
        col_cnt = c + 1;
      end
    end
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    normal_t e;
    if (rst) begin
      width_reg = 1024;
      rows_reg = 1024;
      gain_reg = 32768;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        above_line[i] = '0;
        middle_line[i] = '0;
      end
      prev_center = '0;
      col_cnt = 0;
      row_cnt = 0;
      expected_normals.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: width_reg = 32'(cfg_data[10:0]);
          CFG_IMAGE_ROWS:  rows_reg = 32'(cfg_data[10:0]);
          CFG_HEIGHT_GAIN: gain_reg = 32'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(func, height_sample);
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          report("unexpected transaction, row", pixel_row, -1);
        end else begin
          e = expected_normals.pop_front();
          if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
          if (normal_y !== e.ny) report("normal_y", normal_y, e.ny);
          if (normal_z !== e.nz) report("normal_z", normal_z, e.nz);
          if (pixel_column !== e.col) report("pixel_column", pixel_column, e.col);
          if (pixel_row !== e.row) report("pixel_row", pixel_row, e.row);
          if (frame_end !== e.fend) report("frame_end", frame_end, e.fend);
        end
      end
    end
    pending <= expected_normals.size();
  end

  initial mismatches = 0;

endmodule

FILE: tb/sv/height_map_to_normal_map_tb.sv
`timescale 1ns / 100ps

module height_map_to_normal_map_tb;
  import hmn_pkg::*;

  localparam int   LIMIT = 6000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready, func;
  logic [15:0] height_sample;
  logic        out_valid, out_ready;
  logic [15:0] normal_x, normal_y, normal_z;
  logic [9:0]  pixel_column, pixel_row;
  logic        frame_end;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatches, pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          sent_items = 0;
  logic [15:0] last_height = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  height_map_to_normal_map DUT (.*);
  height_map_to_normal_map_chk chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  int stall_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 400);
      end
      stall_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  task automatic send(logic f, logic [15:0] h);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    height_sample <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_height(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return last_height + 16'($urandom_range(0, 64)) - 16'd32;
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  task automatic run_frame(int w_raw, int rows_raw, logic [15:0] gain);
    int w, rows, mode;
    w = (w_raw < 1) ? 1 : (w_raw > 1024 ? 1024 : w_raw);
    rows = (rows_raw < 1) ? 1 : (rows_raw > 1024 ? 1024 : rows_raw);
    write_reg(CFG_IMAGE_WIDTH, 16'(w_raw));
    write_reg(CFG_IMAGE_ROWS, 16'(rows_raw));
    write_reg(CFG_HEIGHT_GAIN, gain);
    mode = $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) send(FUNC_FLUSH, 16'($urandom));
    for (int i = 0; i < w * rows; i++) begin
      if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 2);
      last_height = pick_height(mode);
      send(FUNC_SAMPLE, last_height);
      sent_items++;
    end
    if ($urandom_range(0, 3) == 0) send(FUNC_SAMPLE, 16'($urandom));
    for (int i = 0; i < w; i++) begin
      send(FUNC_FLUSH, 16'($urandom));
      sent_items++;
    end
    wait_idle();
  endtask

  initial begin
    logic [15:0] gain;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_SAMPLE;
    height_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_frame(2, 2, 16'hFFFF);
    run_frame(1, 1, 16'h0000);
    run_frame(3, 3, 16'h0100);
    run_frame(0, 0, 16'h8000);

    while (sent_items < 850) begin
      case ($urandom_range(0, 3))
        0: gain = 16'h0000;
        1: gain = 16'hFFFF;
        default: gain = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) run_frame(0, 0, gain);
      else if ($urandom_range(0, 4) == 0)
        run_frame($urandom_range(9, 40), $urandom_range(1, 3), gain);
      else run_frame($urandom_range(1, 8), $urandom_range(1, 5), gain);
    end

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
